### hw/rtl/chtt_pkg.sv
// Shared types and codes for the chained hash tag table.
package chtt_pkg;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_POOL_FULL = 2'd2,
    ST_UNUSED    = 2'd3
  } status_t;

  localparam int unsigned CFG_BITS = 9;
  localparam int unsigned WORD_BITS = 32;

endpackage

### hw/rtl/chtt_divmod.sv
// Restoring remainder unit: key hash modulo bucket count, one bit per cycle.
module chtt_divmod #(
  parameter int unsigned DIV_BITS = 17
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [chtt_pkg::WORD_BITS-1:0]     dividend,
  input  logic [DIV_BITS-1:0]                divisor,
  output logic                               done,
  output logic [DIV_BITS-1:0]                remainder
);

  localparam int unsigned CNT_BITS = $clog2(chtt_pkg::WORD_BITS + 1);

  logic [chtt_pkg::WORD_BITS-1:0] shreg;
  logic [DIV_BITS:0]              rem;
  logic [DIV_BITS-1:0]            dvs;
  logic [CNT_BITS-1:0]            cnt;
  logic                           busy;
  logic [DIV_BITS:0]              trial;

  always_comb begin
    trial = {rem[DIV_BITS-1:0], shreg[chtt_pkg::WORD_BITS-1]};
  end

  assign remainder = rem[DIV_BITS-1:0];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
      cnt   <= CNT_BITS'(chtt_pkg::WORD_BITS);
    end else if (busy) begin
      shreg <= {shreg[chtt_pkg::WORD_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) rem <= trial - {1'b0, dvs};
      else rem <= trial;
      cnt <= cnt - 1'b1;
      if (cnt == CNT_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

### hw/rtl/chained_hash_tag_table.sv
// Top level of the chained hash tag table: sequencer around head and node memories.
// Each transaction on the input channel is one put, remove or get on a table keyed
// by a 32-bit key hash (zero marks an empty slot). The bucket is key_hash modulo
// bucket_count, found by a bit-serial remainder unit that holds the sequencer until
// the remainder is handed over. The head store (hash, payload, link) and the
// overflow node pool are synchronous memories with a registered read; a chain walk
// spends a read state and a compare state on each node visited. The block is ready
// again the cycle after its result transaction is taken. One result transaction
// follows each input transaction and only one operation is in progress at a time.
// After reset a clearing pass over all BUCKETS head entries zeroes the head hashes
// and links; no input transaction is taken during it, while configuration writes
// are taken as ever.
module chained_hash_tag_table #(
  parameter int unsigned BUCKETS    = 256,
  parameter int unsigned POOL_NODES = 256,
  parameter int unsigned TAG_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] key_hash,
  input  logic [31:0] tag_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] result_hash,
  output logic [31:0] tag_out,
  output logic [31:0] entry_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);

  localparam int unsigned BI_BITS  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned NI_BITS  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned LNK_BITS = $clog2(POOL_NODES + 1);
  localparam int unsigned DIV_BITS = $clog2(BUCKETS + 1);
  localparam int unsigned CFG_BITS_L = chtt_pkg::CFG_BITS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_HREAD, S_HEAD, S_NREAD, S_NODE, S_RESP
  } state_t;

  state_t state;

  // Memories: head store and node pool.
  logic [31:0]          head_hash_mem [BUCKETS];
  logic [TAG_BITS-1:0]  head_tag_mem  [BUCKETS];
  logic [LNK_BITS-1:0]  head_link_mem [BUCKETS];
  logic [31:0]          node_hash_mem [POOL_NODES];
  logic [TAG_BITS-1:0]  node_tag_mem  [POOL_NODES];
  logic [LNK_BITS-1:0]  node_link_mem [POOL_NODES];

  logic [31:0]         hh_rd;
  logic [TAG_BITS-1:0] ht_rd;
  logic [LNK_BITS-1:0] hl_rd;
  logic [31:0]         nh_rd;
  logic [TAG_BITS-1:0] nt_rd;
  logic [LNK_BITS-1:0] nl_rd;

  logic [CFG_BITS_L-1:0] bucket_count;

  logic [1:0]          cur_op;
  logic [31:0]         cur_hash;
  logic [TAG_BITS-1:0] cur_tag;
  logic [BI_BITS-1:0]  bucket;
  logic [NI_BITS-1:0]  node_idx;
  logic [LNK_BITS-1:0] nodes_taken;
  logic [31:0]         element_total;
  logic [BI_BITS-1:0]  clr_idx;
  logic [LNK_BITS-1:0] steps;

  logic [DIV_BITS-1:0] divisor;
  logic                div_start;
  logic                div_done;
  logic [DIV_BITS-1:0] div_rem;

  // Effective bucket count: zero acts as one, above BUCKETS acts as BUCKETS.
  always_comb begin
    if (bucket_count == '0) divisor = DIV_BITS'(1);
    else if (32'(bucket_count) > BUCKETS) divisor = DIV_BITS'(BUCKETS);
    else divisor = DIV_BITS'(bucket_count);
  end

  chtt_divmod #(.DIV_BITS(DIV_BITS)) u_divmod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (key_hash),
    .divisor   (divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign div_start = in_valid && in_ready;
  assign out_valid = (state == S_RESP);

  always_ff @(posedge clk) begin
    if (rst) bucket_count <= 9'd256;
    else if (cfg_valid && cfg_ready) bucket_count <= cfg_data;
  end

  // A link is node index plus one; zero and out-of-range values are null.
  function automatic logic link_ok(input logic [LNK_BITS-1:0] l);
    return (l != '0) && (32'(l) <= POOL_NODES);
  endfunction

  // Write strobes, driven by the sequencer below.
  logic                hw_hash_en, hw_tag_en, hw_link_en;
  logic [BI_BITS-1:0]  hw_addr;
  logic [31:0]         hw_hash;
  logic [LNK_BITS-1:0] hw_link;
  logic                nw_hash_en, nw_tag_en, nw_link_en;
  logic [NI_BITS-1:0]  nw_addr;
  logic [31:0]         nw_hash;
  logic [LNK_BITS-1:0] nw_link;
  logic                nl_tail_en;
  logic [LNK_BITS-1:0] new_link;
  logic                pool_has;
  logic [NI_BITS-1:0]  rd_node;

  assign new_link = nodes_taken + 1'b1;
  assign pool_has = 32'(nodes_taken) < POOL_NODES;
  assign rd_node  = NI_BITS'(hl_rd - 1'b1);

  always_comb begin
    hw_hash_en = 1'b0; hw_tag_en = 1'b0; hw_link_en = 1'b0;
    hw_addr = bucket; hw_hash = cur_hash; hw_link = new_link;
    nw_hash_en = 1'b0; nw_tag_en = 1'b0; nw_link_en = 1'b0;
    nw_addr = node_idx; nw_hash = cur_hash; nw_link = '0;
    nl_tail_en = 1'b0;
    unique case (state)
      S_CLEAR: begin
        hw_addr = clr_idx; hw_hash = '0; hw_link = '0;
        hw_hash_en = 1'b1; hw_link_en = 1'b1;
      end
      S_HEAD: begin
        if (cur_op == chtt_pkg::OP_PUT && (hh_rd == '0 || hh_rd == cur_hash)) begin
          hw_hash_en = 1'b1; hw_tag_en = 1'b1;
        end else if (cur_op == chtt_pkg::OP_REMOVE && hh_rd != '0 && hh_rd == cur_hash) begin
          hw_hash_en = 1'b1; hw_hash = '0;
        end else if (cur_op == chtt_pkg::OP_PUT && !link_ok(hl_rd) && pool_has) begin
          hw_link_en = 1'b1;
          nw_addr = NI_BITS'(nodes_taken);
          nw_hash_en = 1'b1; nw_tag_en = 1'b1; nw_link_en = 1'b1;
        end
      end
      S_NODE: begin
        if (cur_op == chtt_pkg::OP_PUT && (nh_rd == '0 || nh_rd == cur_hash)) begin
          nw_hash_en = 1'b1; nw_tag_en = 1'b1;
        end else if (cur_op == chtt_pkg::OP_REMOVE && nh_rd == cur_hash) begin
          nw_hash_en = 1'b1; nw_hash = '0;
        end else if (cur_op == chtt_pkg::OP_PUT &&
                     (!link_ok(nl_rd) || 32'(steps) + 1 >= POOL_NODES) && pool_has) begin
          nw_addr = NI_BITS'(nodes_taken);
          nw_hash_en = 1'b1; nw_tag_en = 1'b1; nw_link_en = 1'b1;
          nl_tail_en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Memory ports: one read, one write (two for node links); read data registered.
  always_ff @(posedge clk) begin
    hh_rd <= head_hash_mem[bucket];
    ht_rd <= head_tag_mem[bucket];
    hl_rd <= head_link_mem[bucket];
    if (hw_hash_en) head_hash_mem[hw_addr] <= hw_hash;
    if (hw_tag_en)  head_tag_mem[hw_addr]  <= cur_tag;
    if (hw_link_en) head_link_mem[hw_addr] <= hw_link;
  end

  always_ff @(posedge clk) begin
    nh_rd <= node_hash_mem[node_idx];
    nt_rd <= node_tag_mem[node_idx];
    nl_rd <= node_link_mem[node_idx];
    if (nw_hash_en) node_hash_mem[nw_addr] <= nw_hash;
    if (nw_tag_en)  node_tag_mem[nw_addr]  <= cur_tag;
    if (nw_link_en) node_link_mem[nw_addr] <= nw_link;
    // Appending a node also points the old tail at it; that entry differs from
    // the new node, so the second write uses the tail index.
    if (nl_tail_en) node_link_mem[node_idx] <= new_link;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      nodes_taken   <= '0;
      element_total <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (32'(clr_idx) == BUCKETS - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cur_op   <= op;
            cur_hash <= key_hash;
            cur_tag  <= TAG_BITS'(tag_in);
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            bucket <= BI_BITS'(div_rem);
            state  <= S_HREAD;
          end
        end
        S_HREAD: state <= S_HEAD;
        S_HEAD: begin
          status      <= chtt_pkg::ST_NOT_FOUND;
          result_hash <= '0;
          tag_out     <= '0;
          state       <= S_RESP;
          steps       <= '0;
          node_idx    <= rd_node;
          entry_count <= element_total;
          unique case (cur_op)
            chtt_pkg::OP_PUT: begin
              element_total <= element_total + 1'b1;
              entry_count   <= element_total + 1'b1;
              status        <= chtt_pkg::ST_OK;
              result_hash   <= cur_hash;
              if (hh_rd == '0 || hh_rd == cur_hash) state <= S_RESP;
              else if (link_ok(hl_rd)) state <= S_NREAD;
              else if (pool_has) nodes_taken <= nodes_taken + 1'b1;
              else begin
                status <= chtt_pkg::ST_POOL_FULL;
                result_hash <= '0;
              end
            end
            chtt_pkg::OP_REMOVE: begin
              if (hh_rd == '0) state <= S_RESP;
              else if (hh_rd == cur_hash) begin
                status        <= chtt_pkg::ST_OK;
                element_total <= element_total - 1'b1;
                entry_count   <= element_total - 1'b1;
              end else if (link_ok(hl_rd)) state <= S_NREAD;
            end
            chtt_pkg::OP_GET: begin
              if (hh_rd == cur_hash) begin
                status  <= chtt_pkg::ST_OK;
                tag_out <= 32'(ht_rd);
              end else if (link_ok(hl_rd)) state <= S_NREAD;
            end
            default: ;
          endcase
        end
        S_NREAD: state <= S_NODE;
        S_NODE: begin
          state <= S_RESP;
          unique case (cur_op)
            chtt_pkg::OP_PUT: begin
              if (nh_rd == '0 || nh_rd == cur_hash) state <= S_RESP;
              else if (link_ok(nl_rd) && 32'(steps) + 1 < POOL_NODES) begin
                node_idx <= NI_BITS'(nl_rd - 1'b1);
                steps    <= steps + 1'b1;
                state    <= S_NREAD;
              end else if (pool_has) nodes_taken <= nodes_taken + 1'b1;
              else begin
                status <= chtt_pkg::ST_POOL_FULL;
                result_hash <= '0;
              end
            end
            chtt_pkg::OP_REMOVE: begin
              if (nh_rd == cur_hash) begin
                status        <= chtt_pkg::ST_OK;
                element_total <= element_total - 1'b1;
                entry_count   <= element_total - 1'b1;
              end else if (link_ok(nl_rd) && 32'(steps) + 1 < POOL_NODES) begin
                node_idx <= NI_BITS'(nl_rd - 1'b1);
                steps    <= steps + 1'b1;
                state    <= S_NREAD;
              end
            end
            default: begin
              if (nh_rd == cur_hash) begin
                status  <= chtt_pkg::ST_OK;
                tag_out <= 32'(nt_rd);
              end else if (link_ok(nl_rd) && 32'(steps) + 1 < POOL_NODES) begin
                node_idx <= NI_BITS'(nl_rd - 1'b1);
                steps    <= steps + 1'b1;
                state    <= S_NREAD;
              end
            end
          endcase
        end
        S_RESP: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // The pool never grows past its size.
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    32'(nodes_taken) <= POOL_NODES) else $error("pool count beyond pool size");

  // A result stays offered until it is taken.
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
    else $error("result changed while stalled");

  // No input is taken while an operation is in progress.
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("input taken during operation");

  // The running count only changes at the end of a head or node lookup step.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(element_total) |-> $past(state) == S_HEAD || $past(state) == S_NODE)
    else $error("count changed outside a lookup step");

endmodule

### dv/testbench.sv
// Self-checking testbench for the chained hash tag table.
module testbench;

  localparam int unsigned SLOTS      = 256;
  localparam int unsigned NODES      = 256;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned SETTLE     = 600;

  typedef struct packed {
    chtt_pkg::status_t status;
    logic [31:0]       result_hash;
    logic [31:0]       tag_out;
    logic [31:0]       entry_count;
  } table_answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = chtt_pkg::OP_NONE;
  logic [31:0] key_hash = '0;
  logic [31:0] tag_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] result_hash;
  logic [31:0] tag_out;
  logic [31:0] entry_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;

  chained_hash_tag_table uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .key_hash(key_hash), .tag_in(tag_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .result_hash(result_hash), .tag_out(tag_out),
    .entry_count(entry_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table contents, used to work out every answer.
  logic [31:0] shadow_head_hash [SLOTS];
  logic [31:0] shadow_head_tag  [SLOTS];
  bit          head_tag_set     [SLOTS];
  int unsigned shadow_head_link [SLOTS];
  logic [31:0] shadow_node_hash [NODES];
  logic [31:0] shadow_node_tag  [NODES];
  int unsigned shadow_node_link [NODES];
  int unsigned shadow_taken;
  logic [31:0] shadow_total;
  logic [8:0]  shadow_buckets;

  table_answer_t pending_answers[$];
  int unsigned   mismatches;
  logic [31:0]   key_set [32];

  // Sender burst state: a burst runs back to back, then a random gap follows.
  int unsigned burst_left;

  // Receiver stall pattern and the style in use.
  logic [15:0] ready_pattern = 16'hF0F3;
  int unsigned ready_style;
  int unsigned style_left;

  function automatic int unsigned bucket_index(logic [31:0] h);
    int unsigned n;
    n = shadow_buckets;
    if (n == 0) n = 1;
    if (n > SLOTS) n = SLOTS;
    return h % n;
  endfunction

  // Applies one operation to the shadow table and returns the answer it gives.
  function automatic table_answer_t apply_table_op(chtt_pkg::op_t o, logic [31:0] h,
                                                   logic [31:0] t);
    table_answer_t a;
    int unsigned b, link, tail, steps, i;
    bit done;
    b = bucket_index(h);
    a = '{status: chtt_pkg::ST_NOT_FOUND, result_hash: '0, tag_out: '0, entry_count: '0};
    done = 1'b0;
    case (o)
      chtt_pkg::OP_PUT: begin
        shadow_total += 1;
        a.status = chtt_pkg::ST_OK;
        a.result_hash = h;
        if (shadow_head_hash[b] == 0 || shadow_head_hash[b] == h) begin
          shadow_head_hash[b] = h;
          shadow_head_tag[b] = t;
          head_tag_set[b] = 1'b1;
          done = 1'b1;
        end
        tail = NODES;
        link = shadow_head_link[b];
        for (steps = 0; !done && steps < NODES && link != 0; steps++) begin
          i = link - 1;
          if (shadow_node_hash[i] == 0 || shadow_node_hash[i] == h) begin
            shadow_node_hash[i] = h;
            shadow_node_tag[i] = t;
            done = 1'b1;
          end else begin
            tail = i;
            link = shadow_node_link[i];
          end
        end
        if (!done) begin
          if (shadow_taken < NODES) begin
            i = shadow_taken;
            shadow_taken += 1;
            shadow_node_hash[i] = h;
            shadow_node_tag[i] = t;
            shadow_node_link[i] = 0;
            if (tail >= NODES) shadow_head_link[b] = i + 1;
            else shadow_node_link[tail] = i + 1;
          end else begin
            a.status = chtt_pkg::ST_POOL_FULL;
            a.result_hash = '0;
          end
        end
      end
      chtt_pkg::OP_REMOVE: begin
        if (shadow_head_hash[b] != 0) begin
          if (shadow_head_hash[b] == h) begin
            shadow_head_hash[b] = '0;
            shadow_total -= 1;
            a.status = chtt_pkg::ST_OK;
          end else begin
            link = shadow_head_link[b];
            for (steps = 0; !done && steps < NODES && link != 0; steps++) begin
              i = link - 1;
              if (shadow_node_hash[i] == h) begin
                shadow_node_hash[i] = '0;
                shadow_total -= 1;
                a.status = chtt_pkg::ST_OK;
                done = 1'b1;
              end else begin
                link = shadow_node_link[i];
              end
            end
          end
        end
      end
      chtt_pkg::OP_GET: begin
        if (shadow_head_hash[b] == h) begin
          a.status = chtt_pkg::ST_OK;
          a.tag_out = shadow_head_tag[b];
        end else begin
          link = shadow_head_link[b];
          for (steps = 0; !done && steps < NODES && link != 0; steps++) begin
            i = link - 1;
            if (shadow_node_hash[i] == h) begin
              a.status = chtt_pkg::ST_OK;
              a.tag_out = shadow_node_tag[i];
              done = 1'b1;
            end else begin
              link = shadow_node_link[i];
            end
          end
        end
      end
      default: ;
    endcase
    a.entry_count = shadow_total;
    return a;
  endfunction

  // Offers one operation, honouring the burst and gap scheme, and records the answer
  // expected once the transaction is taken. Valid is only lowered when a gap starts, so
  // back-to-back operations never see valid dropped and raised within one step.
  task automatic send_op(chtt_pkg::op_t o, logic [31:0] h, logic [31:0] t);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    // A get with key zero reads bucket zero's payload, which must have been written.
    if (o == chtt_pkg::OP_GET && h == 0 && !head_tag_set[0]) h = 32'd1;
    in_valid <= 1'b1;
    op <= o;
    key_hash <= h;
    tag_in <= t;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(apply_table_op(o, h, t));
  endtask

  // Stops offering operations and waits until every answer has come back.
  task automatic drain_table;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_bucket_count(logic [8:0] value);
    drain_table();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow_buckets = value;
    cfg_valid <= 1'b0;
  endtask

  // Mostly keys from a small set that crowds a few buckets, some near misses,
  // some wholly random keys and the odd zero key.
  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return key_set[$urandom_range(0, 31)];
    if (r < 70) return key_set[$urandom_range(0, 31)] ^ (32'h1 << $urandom_range(8, 31));
    if (r < 98) return $urandom;
    return 32'd0;
  endfunction

  function automatic chtt_pkg::op_t pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return chtt_pkg::OP_PUT;
    if (r < 68) return chtt_pkg::OP_REMOVE;
    if (r < 97) return chtt_pkg::OP_GET;
    return chtt_pkg::OP_NONE;
  endfunction

  task automatic run_random(int unsigned count);
    for (int unsigned n = 0; n < count; n++) send_op(pick_op(), pick_key(), $urandom);
  endtask

  // Extremes of the fields, each operation and the corner cases, at the reset setting.
  task automatic test_directed;
    send_op(chtt_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);
    send_op(chtt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_op(chtt_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(chtt_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);
    send_op(chtt_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
    send_op(chtt_pkg::OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(chtt_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Zero key: stored literally, the slot still reads as empty.
    send_op(chtt_pkg::OP_PUT, 32'd0, 32'hA5A5_5A5A);
    send_op(chtt_pkg::OP_GET, 32'd0, 32'h0);
    send_op(chtt_pkg::OP_REMOVE, 32'd0, 32'h0);
    // Three keys in bucket five build a chain; the middle one is removed and recycled.
    send_op(chtt_pkg::OP_PUT, 32'd5, 32'h0000_0001);
    send_op(chtt_pkg::OP_PUT, 32'd261, 32'h0000_0002);
    send_op(chtt_pkg::OP_PUT, 32'd517, 32'h0000_0003);
    send_op(chtt_pkg::OP_GET, 32'd517, 32'h0);
    send_op(chtt_pkg::OP_REMOVE, 32'd261, 32'h0);
    send_op(chtt_pkg::OP_REMOVE, 32'd261, 32'h0);
    send_op(chtt_pkg::OP_REMOVE, 32'd773, 32'h0);
    send_op(chtt_pkg::OP_PUT, 32'd1029, 32'h0000_0004);
    send_op(chtt_pkg::OP_GET, 32'd1029, 32'h0);
    send_op(chtt_pkg::OP_GET, 32'd261, 32'h0);
    send_op(chtt_pkg::OP_REMOVE, 32'd5, 32'h0);
    send_op(chtt_pkg::OP_GET, 32'd517, 32'h0);
    send_op(chtt_pkg::OP_PUT, 32'd5, 32'h0000_0000);
  endtask

  // Runs random traffic under several bucket counts, the extremes and the
  // out-of-range values among them; stored entries stay where they were put.
  task automatic test_bucket_counts;
    logic [8:0] settings [6] = '{9'd1, 9'd0, 9'd511, 9'd7, 9'd256, 9'd100};
    foreach (settings[s]) begin
      write_bucket_count(settings[s]);
      run_random(100);
    end
  endtask

  // Fresh keys fill the overflow pool so that later puts answer pool full.
  task automatic test_pool_exhaustion;
    write_bucket_count(9'd2);
    for (int unsigned n = 0; n < 300; n++) begin
      send_op(chtt_pkg::OP_PUT, $urandom | 32'h1, $urandom);
    end
    run_random(200);
  endtask

  // Random traffic at the reset bucket count, with one pause that lets the block run dry.
  task automatic test_mixed_traffic;
    write_bucket_count(9'd256);
    run_random(250);
    drain_table();
    run_random(250);
  endtask

  initial begin
    foreach (key_set[i]) key_set[i] = (i % 8) + 256 * $urandom_range(1, 1 << 20);
    for (int unsigned i = 0; i < SLOTS; i++) begin
      shadow_head_hash[i] = '0;
      shadow_head_link[i] = 0;
      head_tag_set[i] = 1'b0;
    end
    shadow_taken = 0;
    shadow_total = '0;
    shadow_buckets = 9'd256;
    mismatches = 0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_bucket_counts();
    test_pool_exhaustion();
    test_mixed_traffic();
    drain_table();
    repeat (SETTLE) @(posedge clk);
    mismatches += pending_answers.size();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // The receiver cycles through styles: always ready, random stalls and a rotating pattern.
  always @(posedge clk) begin
    if (style_left == 0) begin
      ready_style <= $urandom_range(0, 2);
      style_left <= $urandom_range(20, 200);
    end else begin
      style_left <= style_left - 1;
    end
    ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
    case (ready_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 2) != 0);
      default: out_ready <= ready_pattern[0];
    endcase
  end

  // Compares every answer transaction with the oldest one outstanding.
  always @(posedge clk) begin
    table_answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected answer: status %0d hash %h", status, result_hash);
        end
      end else begin
        want = pending_answers.pop_front();
        if (status !== want.status || result_hash !== want.result_hash ||
            tag_out !== want.tag_out || entry_count !== want.entry_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected st %0d hash %h tag %h cnt %h, ",
                      "got st %0d hash %h tag %h cnt %h"},
                     want.status, want.result_hash, want.tag_out, want.entry_count,
                     status, result_hash, tag_out, entry_count);
        end
      end
    end
  end

  // Ends the run if no transaction of any kind is taken for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### sim.f
hw/rtl/chtt_pkg.sv
hw/rtl/chtt_divmod.sv
hw/rtl/chained_hash_tag_table.sv
dv/testbench.sv
